// ===== rtl/core/efsa_pkg.sv =====
// ----------------------------------------------------------------------------
// efsa_pkg
// shared types, constants and helpers of the earliest-finish server scheduler
// ----------------------------------------------------------------------------
package efsa_pkg;

    localparam int MAX_SERVERS = 16;
    localparam int SRV_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CNT_W       = $clog2(MAX_SERVERS + 1);

    localparam int MODE_W      = 2;
    localparam int INDEX_W     = 4;
    localparam int AMOUNT_W    = 8;
    localparam int UNIT_W      = 8;
    localparam int PROD_W      = AMOUNT_W + UNIT_W;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [MODE_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_JOB   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [INDEX_W-1:0]  server_index;
        logic [AMOUNT_W-1:0] amount;
    } request_t;

    typedef struct packed {
        logic [INDEX_W-1:0] assigned_server;
        logic [TIME_W-1:0]  server_finish;
        logic [TIME_W-1:0]  makespan;
        logic               saturated;
    } result_t;

    // servers in use: zero acts as one, anything above the table acts as full
    function automatic logic [CNT_W-1:0] servers_in_use(input logic [CFG_W-1:0] cfg);
        logic [CNT_W-1:0] n;
        n = '0;
        if (cfg == '0)
        begin
            n = CNT_W'(1);
        end
        else if (32'(cfg) > 32'(MAX_SERVERS))
        begin
            n = CNT_W'(MAX_SERVERS);
        end
        else
        begin
            n = CNT_W'(cfg);
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/efsa_front.sv =====
// ----------------------------------------------------------------------------
// efsa_front
// request intake: decodes the mode and buffers requests for the back end
// ----------------------------------------------------------------------------
module efsa_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [efsa_pkg::MODE_W-1:0]    mode,
    input  logic [efsa_pkg::INDEX_W-1:0]   server_index,
    input  logic [efsa_pkg::AMOUNT_W-1:0]  amount,
    output logic                           req_valid,
    output efsa_pkg::request_t             req,
    input  logic                           req_take
);

    efsa_pkg::request_t              mem_reg [efsa_pkg::QUEUE_DEPTH];
    logic [efsa_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [efsa_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [efsa_pkg::QCNT_W-1:0]     count_reg, count_next;
    efsa_pkg::request_t              decoded;
    logic                            do_write;
    logic                            do_read;

    // mode decoder
    always_comb
    begin
        decoded.server_index = server_index;
        decoded.amount       = amount;
        unique case (mode)
            efsa_pkg::OP_LOAD:  decoded.op = efsa_pkg::OP_LOAD;
            efsa_pkg::OP_JOB:   decoded.op = efsa_pkg::OP_JOB;
            efsa_pkg::OP_CLEAR: decoded.op = efsa_pkg::OP_CLEAR;
            default:            decoded.op = efsa_pkg::OP_NOP;
        endcase
    end

    assign full      = (count_reg == efsa_pkg::QCNT_W'(efsa_pkg::QUEUE_DEPTH));
    assign req_valid = (count_reg != '0);
    assign req       = mem_reg[rd_ptr_reg];
    assign do_write  = push && !full;
    assign do_read   = req_take && req_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_write)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == efsa_pkg::QUEUE_DEPTH - 1) ? '0
                        : wr_ptr_reg + efsa_pkg::QPTR_W'(1);
        end
        if (do_read)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == efsa_pkg::QUEUE_DEPTH - 1) ? '0
                        : rd_ptr_reg + efsa_pkg::QPTR_W'(1);
        end
        if (do_write && !do_read)
        begin
            count_next = count_reg + efsa_pkg::QCNT_W'(1);
        end
        else if (!do_write && do_read)
        begin
            count_next = count_reg - efsa_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ===== rtl/core/efsa_result_queue.sv =====
// ----------------------------------------------------------------------------
// efsa_result_queue
// small result buffer between the back end and the result ports
// ----------------------------------------------------------------------------
module efsa_result_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_push,
    input  efsa_pkg::result_t res_data,
    output logic              res_space,
    output logic              empty,
    input  logic              pop,
    output efsa_pkg::result_t head
);

    efsa_pkg::result_t               mem_reg [efsa_pkg::QUEUE_DEPTH];
    logic [efsa_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [efsa_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [efsa_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                            do_write;
    logic                            do_read;

    assign res_space = (count_reg != efsa_pkg::QCNT_W'(efsa_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_write  = res_push && res_space;
    assign do_read   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_write)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == efsa_pkg::QUEUE_DEPTH - 1) ? '0
                        : wr_ptr_reg + efsa_pkg::QPTR_W'(1);
        end
        if (do_read)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == efsa_pkg::QUEUE_DEPTH - 1) ? '0
                        : rd_ptr_reg + efsa_pkg::QPTR_W'(1);
        end
        if (do_write && !do_read)
        begin
            count_next = count_reg + efsa_pkg::QCNT_W'(1);
        end
        else if (!do_write && do_read)
        begin
            count_next = count_reg - efsa_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem_reg[wr_ptr_reg] <= res_data;
        end
    end

endmodule

// ===== rtl/core/efsa_back.sv =====
// ----------------------------------------------------------------------------
// efsa_back
// execution: unit time table, finish times, min scan, multiply and update
// ----------------------------------------------------------------------------
module efsa_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [efsa_pkg::CFG_W-1:0]    num_servers_cfg,
    input  logic                          req_valid,
    input  efsa_pkg::request_t            req,
    output logic                          req_take,
    input  logic                          res_space,
    output logic                          res_push,
    output efsa_pkg::result_t             res_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_ADD  = 4'b1000
    } state_t;

    state_t                            state_reg, state_next;
    logic [efsa_pkg::TIME_W-1:0]       finish_reg [efsa_pkg::MAX_SERVERS];
    logic [efsa_pkg::UNIT_W-1:0]       unit_reg   [efsa_pkg::MAX_SERVERS];
    logic [efsa_pkg::SRV_W-1:0]        chosen_reg, chosen_next;
    logic [efsa_pkg::SRV_W-1:0]        idx_reg, idx_next;
    logic [efsa_pkg::TIME_W-1:0]       best_reg, best_next;
    logic [efsa_pkg::CNT_W-1:0]        placed_reg, placed_next;
    logic [efsa_pkg::TIME_W-1:0]       longest_reg, longest_next;
    logic [efsa_pkg::AMOUNT_W-1:0]     amount_reg, amount_next;
    logic [efsa_pkg::PROD_W-1:0]       prod_reg, prod_next;

    logic [efsa_pkg::CNT_W-1:0]        n_eff;
    logic [efsa_pkg::SRV_W-1:0]        rd_idx;
    logic [efsa_pkg::TIME_W-1:0]       finish_rd;
    logic [efsa_pkg::TIME_W:0]         sum;
    logic                              sat;
    logic [efsa_pkg::TIME_W-1:0]       finish_new;
    logic                              scan_last;
    logic                              unit_we;
    logic                              fin_we;
    logic                              clear_all;

    assign n_eff      = efsa_pkg::servers_in_use(num_servers_cfg);
    assign rd_idx     = (state_reg == ST_SCAN) ? idx_reg : chosen_reg;
    assign finish_rd  = finish_reg[rd_idx];
    assign sum        = {1'b0, finish_rd} + (efsa_pkg::TIME_W + 1)'(prod_reg);
    assign sat        = sum[efsa_pkg::TIME_W];
    assign finish_new = sat ? '1 : sum[efsa_pkg::TIME_W-1:0];
    assign scan_last  = (efsa_pkg::CNT_W'(idx_reg) + efsa_pkg::CNT_W'(1)) == n_eff;

    always_comb
    begin
        state_next   = state_reg;
        chosen_next  = chosen_reg;
        idx_next     = idx_reg;
        best_next    = best_reg;
        placed_next  = placed_reg;
        longest_next = longest_reg;
        amount_next  = amount_reg;
        prod_next    = prod_reg;
        req_take     = 1'b0;
        res_push     = 1'b0;
        unit_we      = 1'b0;
        fin_we       = 1'b0;
        clear_all    = 1'b0;
        res_data.assigned_server = '0;
        res_data.server_finish   = '0;
        res_data.makespan        = longest_reg;
        res_data.saturated       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && res_space)
                begin
                    req_take = 1'b1;
                    case (req.op)
                        efsa_pkg::OP_LOAD:
                        begin
                            unit_we  = (32'(req.server_index) < 32'(efsa_pkg::MAX_SERVERS));
                            res_push = 1'b1;
                        end
                        efsa_pkg::OP_CLEAR:
                        begin
                            clear_all         = 1'b1;
                            placed_next       = '0;
                            longest_next      = '0;
                            res_data.makespan = '0;
                            res_push          = 1'b1;
                        end
                        efsa_pkg::OP_JOB:
                        begin
                            amount_next = req.amount;
                            if (placed_reg < n_eff)
                            begin
                                // in-order placement phase
                                chosen_next = efsa_pkg::SRV_W'(placed_reg);
                                placed_next = placed_reg + efsa_pkg::CNT_W'(1);
                                state_next  = ST_MUL;
                            end
                            else
                            begin
                                chosen_next = '0;
                                best_next   = finish_reg[0];
                                idx_next    = efsa_pkg::SRV_W'(1);
                                state_next  = (n_eff == efsa_pkg::CNT_W'(1)) ? ST_MUL : ST_SCAN;
                            end
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // strict compare keeps the lowest index on a tie
                if (finish_rd < best_reg)
                begin
                    best_next   = finish_rd;
                    chosen_next = idx_reg;
                end
                if (scan_last)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    idx_next = idx_reg + efsa_pkg::SRV_W'(1);
                end
            end
            ST_MUL:
            begin
                prod_next  = efsa_pkg::PROD_W'(amount_reg) * efsa_pkg::PROD_W'(unit_reg[chosen_reg]);
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                fin_we = 1'b1;
                if (finish_new > longest_reg)
                begin
                    longest_next = finish_new;
                end
                res_data.assigned_server = efsa_pkg::INDEX_W'(chosen_reg);
                res_data.server_finish   = finish_new;
                res_data.makespan        = (finish_new > longest_reg) ? finish_new : longest_reg;
                res_data.saturated       = sat;
                res_push                 = 1'b1;
                state_next               = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            placed_reg  <= '0;
            longest_reg <= '0;
            for (int i = 0; i < efsa_pkg::MAX_SERVERS; i++)
            begin
                finish_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            placed_reg  <= placed_next;
            longest_reg <= longest_next;
            if (clear_all)
            begin
                for (int i = 0; i < efsa_pkg::MAX_SERVERS; i++)
                begin
                    finish_reg[i] <= '0;
                end
            end
            else if (fin_we)
            begin
                finish_reg[chosen_reg] <= finish_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chosen_reg <= chosen_next;
        idx_reg    <= idx_next;
        best_reg   <= best_next;
        amount_reg <= amount_next;
        prod_reg   <= prod_next;
        if (unit_we)
        begin
            unit_reg[efsa_pkg::SRV_W'(req.server_index)] <= req.amount;
        end
    end

    // results are only produced when the result queue was checked to have room
    a_push_has_space: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> res_space)
        else $error("result pushed into full queue");

    // in-order count never passes the table depth
    a_placed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(placed_reg) <= efsa_pkg::MAX_SERVERS)
        else $error("in-order placement count out of range");

    // scan index stays inside the servers in use
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (efsa_pkg::CNT_W'(idx_reg) < n_eff))
        else $error("scan index beyond servers in use");

    // clear resets makespan and in-order phase
    a_clear_effect: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && req_take && req.op == efsa_pkg::OP_CLEAR)
        |=> (longest_reg == '0 && placed_reg == '0))
        else $error("clear did not reset scheduler state");

    // every job ends with exactly one result from the update step
    a_add_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> (state_reg == ST_ADD && res_push))
        else $error("job update step did not emit a result");

endmodule

// ===== rtl/core/earliest_finish_server_assign_top.sv =====
// ----------------------------------------------------------------------------
// earliest_finish_server_assign_top
// greedy list scheduler sending each job to the server that frees up first
// ----------------------------------------------------------------------------
// path: every request passes the request queue, the back end and the result queue;
//   a job placed in order goes through the multiply and update states, a scheduled job
//   first scans the n servers in use (one finish-time compare per cycle)
// throughput: one non-job request per cycle while the result queue has room, none during a job
// reset: finish times, makespan and placement count cleared, servers in use 16,
//   unit times undefined until loaded, both queues empty
module earliest_finish_server_assign_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [efsa_pkg::MODE_W-1:0]    mode,
    input  logic [efsa_pkg::INDEX_W-1:0]   server_index,
    input  logic [efsa_pkg::AMOUNT_W-1:0]  amount,
    output logic                           empty,
    input  logic                           pop,
    output logic [efsa_pkg::INDEX_W-1:0]   assigned_server,
    output logic [efsa_pkg::TIME_W-1:0]    server_finish,
    output logic [efsa_pkg::TIME_W-1:0]    makespan,
    output logic                           saturated,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [efsa_pkg::CFG_W-1:0]     num_servers
);

    logic [efsa_pkg::CFG_W-1:0] num_servers_reg;
    logic                       req_valid;
    efsa_pkg::request_t         req;
    logic                       req_take;
    logic                       res_space;
    logic                       res_push;
    efsa_pkg::result_t          res_data;
    efsa_pkg::result_t          head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_servers_reg <= efsa_pkg::CFG_W'(efsa_pkg::MAX_SERVERS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            num_servers_reg <= num_servers;
        end
    end

    efsa_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .server_index (server_index),
        .amount       (amount),
        .req_valid    (req_valid),
        .req          (req),
        .req_take     (req_take)
    );

    efsa_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .num_servers_cfg (num_servers_reg),
        .req_valid       (req_valid),
        .req             (req),
        .req_take        (req_take),
        .res_space       (res_space),
        .res_push        (res_push),
        .res_data        (res_data)
    );

    efsa_result_queue u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res_data  (res_data),
        .res_space (res_space),
        .empty     (empty),
        .pop       (pop),
        .head      (head)
    );

    assign assigned_server = head.assigned_server;
    assign server_finish   = head.server_finish;
    assign makespan        = head.makespan;
    assign saturated       = head.saturated;

endmodule

// ===== sim/tb_earliest_finish_server_assign_top.sv =====
// ----------------------------------------------------------------------------
// tb_earliest_finish_server_assign_top
// self-checking bench for the greedy least-loaded server scheduler: requests
// are queued and driven with random gaps, and every result is compared field
// by field with a cycle-free copy of the scheduler kept alongside the block
// ----------------------------------------------------------------------------
module tb_earliest_finish_server_assign_top;

    localparam int SUM_W = efsa_pkg::TIME_W + 1;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          push         = 1'b0;
    logic                          full;
    logic [efsa_pkg::MODE_W-1:0]   mode         = '0;
    logic [efsa_pkg::INDEX_W-1:0]  server_index = '0;
    logic [efsa_pkg::AMOUNT_W-1:0] amount       = '0;
    logic                          empty;
    logic                          pop          = 1'b0;
    logic [efsa_pkg::INDEX_W-1:0]  assigned_server;
    logic [efsa_pkg::TIME_W-1:0]   server_finish;
    logic [efsa_pkg::TIME_W-1:0]   makespan;
    logic                          saturated;
    logic                          cfg_valid    = 1'b0;
    logic                          cfg_ready;
    logic [efsa_pkg::CFG_W-1:0]    num_servers  = 5'd16;

    // scheduler copy
    logic [efsa_pkg::UNIT_W-1:0]   unit_time [efsa_pkg::MAX_SERVERS];
    logic [efsa_pkg::TIME_W-1:0]   finish_at [efsa_pkg::MAX_SERVERS];
    logic [efsa_pkg::CNT_W-1:0]    placed_count;
    logic [efsa_pkg::TIME_W-1:0]   span;
    logic [efsa_pkg::CFG_W-1:0]    servers_cfg;

    efsa_pkg::request_t            pending_requests [$];
    efsa_pkg::result_t             expected_results [$];
    efsa_pkg::request_t            next_req;
    efsa_pkg::request_t            incoming;
    efsa_pkg::result_t             want;

    int                  send_gap;
    int                  take_gap;
    int                  draw;
    int                  fail_count   = 0;
    int                  results_checked = 0;
    int                  saturated_seen  = 0;
    int                  op_seen [4]  = '{0, 0, 0, 0};

    earliest_finish_server_assign_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .mode            (mode),
        .server_index    (server_index),
        .amount          (amount),
        .empty           (empty),
        .pop             (pop),
        .assigned_server (assigned_server),
        .server_finish   (server_finish),
        .makespan        (makespan),
        .saturated       (saturated),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .num_servers     (num_servers)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic efsa_pkg::result_t predict_outcome(input efsa_pkg::request_t r);
        efsa_pkg::result_t          res;
        logic [efsa_pkg::CNT_W-1:0] active;
        logic [efsa_pkg::SRV_W-1:0] pick;
        logic [SUM_W-1:0]           total;
        res = '0;
        case (r.op)
            efsa_pkg::OP_LOAD:
            begin
                unit_time[r.server_index] = r.amount;
            end
            efsa_pkg::OP_JOB:
            begin
                if (servers_cfg == '0)
                begin
                    active = efsa_pkg::CNT_W'(1);
                end
                else if (32'(servers_cfg) > 32'(efsa_pkg::MAX_SERVERS))
                begin
                    active = efsa_pkg::CNT_W'(efsa_pkg::MAX_SERVERS);
                end
                else
                begin
                    active = efsa_pkg::CNT_W'(servers_cfg);
                end
                if (placed_count < active)
                begin
                    pick = efsa_pkg::SRV_W'(placed_count);
                    placed_count = placed_count + efsa_pkg::CNT_W'(1);
                end
                else
                begin
                    // lowest index wins a tie
                    pick = '0;
                    for (int i = 1; i < int'(active); i++)
                    begin
                        if (finish_at[i] < finish_at[pick])
                        begin
                            pick = efsa_pkg::SRV_W'(i);
                        end
                    end
                end
                total = {1'b0, finish_at[pick]}
                      + SUM_W'(r.amount) * SUM_W'(unit_time[pick]);
                if (total[efsa_pkg::TIME_W])
                begin
                    total = {1'b0, {efsa_pkg::TIME_W{1'b1}}};
                    res.saturated = 1'b1;
                end
                finish_at[pick] = total[efsa_pkg::TIME_W-1:0];
                if (finish_at[pick] > span)
                begin
                    span = finish_at[pick];
                end
                res.assigned_server = efsa_pkg::INDEX_W'(pick);
                res.server_finish   = finish_at[pick];
            end
            efsa_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < efsa_pkg::MAX_SERVERS; i++)
                begin
                    finish_at[i] = '0;
                end
                placed_count = '0;
                span         = '0;
            end
            default:
            begin
            end
        endcase
        res.makespan = span;
        return res;
    endfunction

    task automatic add_request(input efsa_pkg::op_t op,
                               input logic [efsa_pkg::INDEX_W-1:0] idx,
                               input logic [efsa_pkg::AMOUNT_W-1:0] amt);
        efsa_pkg::request_t r;
        r.op           = op;
        r.server_index = idx;
        r.amount       = amt;
        pending_requests.push_back(r);
    endtask

    // sampled at the falling edge so the driver's state has settled
    task automatic wait_drained();
        @(negedge clk);
        while (pending_requests.size() != 0 || push || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic set_server_count(input logic [efsa_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid   <= 1'b1;
        num_servers <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push         <= 1'b0;
            mode         <= efsa_pkg::OP_NOP;
            server_index <= '0;
            amount       <= '0;
            send_gap     <= 0;
        end
        else if (!(push && full))
        begin
            if (send_gap != 0)
            begin
                push     <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_requests.size() != 0)
            begin
                next_req      = pending_requests.pop_front();
                push         <= 1'b1;
                mode         <= next_req.op;
                server_index <= next_req.server_index;
                amount       <= next_req.amount;
                send_gap     <= $urandom_range(0, 16);
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // monitor: predicts on accepted requests, checks popped results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop          <= 1'b0;
            take_gap     <= 0;
            servers_cfg   = 5'd16;
            placed_count  = '0;
            span          = '0;
            for (int i = 0; i < efsa_pkg::MAX_SERVERS; i++)
            begin
                unit_time[i] = '0;
                finish_at[i] = '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                servers_cfg = num_servers;
            end
            if (push && !full)
            begin
                incoming.op           = efsa_pkg::op_t'(mode);
                incoming.server_index = server_index;
                incoming.amount       = amount;
                op_seen[mode]++;
                expected_results.push_back(predict_outcome(incoming));
            end
            if (pop && !empty)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    $error("result popped with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.saturated)
                    begin
                        saturated_seen++;
                    end
                    if (assigned_server !== want.assigned_server)
                    begin
                        $error("assigned_server: expected %0d, got %0d",
                               want.assigned_server, assigned_server);
                        fail_count++;
                    end
                    if (server_finish !== want.server_finish)
                    begin
                        $error("server_finish: expected %0d, got %0d",
                               want.server_finish, server_finish);
                        fail_count++;
                    end
                    if (makespan !== want.makespan)
                    begin
                        $error("makespan: expected %0d, got %0d", want.makespan, makespan);
                        fail_count++;
                    end
                    if (saturated !== want.saturated)
                    begin
                        $error("saturated: expected %0d, got %0d", want.saturated, saturated);
                        fail_count++;
                    end
                end
                draw      = $urandom_range(0, 16);
                pop      <= (draw == 0);
                take_gap <= draw;
            end
            else if (!pop)
            begin
                if (take_gap > 1)
                begin
                    take_gap <= take_gap - 1;
                end
                else
                begin
                    take_gap <= 0;
                    pop      <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        logic [efsa_pkg::CFG_W-1:0]    cfg_plan [10];
        efsa_pkg::op_t                 pick_op;
        logic [efsa_pkg::AMOUNT_W-1:0] amt;
        int                            roll;

        cfg_plan = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd17, 5'd0, 5'd2, 5'd16, 5'd9, 5'd3};
        cfg_plan[8] = efsa_pkg::CFG_W'($urandom_range(1, 16));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // unit times for every server, extremes on the first and last
        for (int i = 0; i < efsa_pkg::MAX_SERVERS; i++)
        begin
            if (i == 0)
            begin
                add_request(efsa_pkg::OP_LOAD, efsa_pkg::INDEX_W'(i), 8'd255);
            end
            else if (i == efsa_pkg::MAX_SERVERS - 1)
            begin
                add_request(efsa_pkg::OP_LOAD, efsa_pkg::INDEX_W'(i), 8'd0);
            end
            else
            begin
                add_request(efsa_pkg::OP_LOAD, efsa_pkg::INDEX_W'(i),
                            efsa_pkg::AMOUNT_W'(i * 37 + 11));
            end
        end
        add_request(efsa_pkg::OP_JOB, 4'd0, 8'd255);
        add_request(efsa_pkg::OP_JOB, 4'd15, 8'd0);
        add_request(efsa_pkg::OP_NOP, 4'd15, 8'd255);
        add_request(efsa_pkg::OP_CLEAR, 4'd0, 8'd0);
        wait_drained();

        // two servers, zero work then a tie on the finish times
        set_server_count(5'd2);
        add_request(efsa_pkg::OP_JOB, 4'd0, 8'd0);
        add_request(efsa_pkg::OP_JOB, 4'd0, 8'd0);
        add_request(efsa_pkg::OP_JOB, 4'd0, 8'd7);
        add_request(efsa_pkg::OP_JOB, 4'd0, 8'd3);
        wait_drained();

        // count of zero acts as one server: all work lands on server 0
        set_server_count(5'd0);
        add_request(efsa_pkg::OP_CLEAR, 4'd0, 8'd0);
        repeat (20) add_request(efsa_pkg::OP_JOB, 4'd9, 8'd255);
        add_request(efsa_pkg::OP_NOP, 4'd0, 8'd0);
        add_request(efsa_pkg::OP_CLEAR, 4'd0, 8'd0);
        wait_drained();

        for (int p = 0; p < 10; p++)
        begin
            set_server_count(cfg_plan[p]);
            for (int k = 0; k < 75; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                begin
                    pick_op = efsa_pkg::OP_JOB;
                end
                else if (roll < 85)
                begin
                    pick_op = efsa_pkg::OP_LOAD;
                end
                else if (roll < 94)
                begin
                    pick_op = efsa_pkg::OP_CLEAR;
                end
                else
                begin
                    pick_op = efsa_pkg::OP_NOP;
                end
                roll = $urandom_range(0, 9);
                if (roll == 0)
                begin
                    amt = 8'd0;
                end
                else if (roll == 1)
                begin
                    amt = 8'd255;
                end
                else
                begin
                    amt = efsa_pkg::AMOUNT_W'($urandom_range(0, 255));
                end
                add_request(pick_op, efsa_pkg::INDEX_W'($urandom_range(0, 15)), amt);
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("ran %0d requests: %0d loads, %0d jobs, %0d clears, %0d unused mode",
                 op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
        $display("%0d results compared, %0d clipped finish times, %0d mismatches",
                 results_checked, saturated_seen, fail_count);
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
